/* rtl/dda_pkg.sv */
// Shared types, constants and helpers for the grid ray traversal unit.
// No dependencies; imported by rtl/dda_grid_ray_traversal_unit.sv.

package dda_pkg;

	localparam int GRID_COORD_BITS = 6;
	localparam int DIST_BITS       = 32;
	localparam int FRAC_BITS       = 16;

	localparam int SIZE_BITS    = GRID_COORD_BITS + 1;
	localparam int ADDR_BITS    = 2 * GRID_COORD_BITS;
	localparam int CFG_IDX_BITS = 1;

	localparam logic [SIZE_BITS-1:0] GRID_SIZE = SIZE_BITS'(1) << GRID_COORD_BITS;
	localparam logic [DIST_BITS-1:0] DIST_MAX  = '1;
	localparam logic [ADDR_BITS-1:0] CLR_LAST  = '1;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_BITS-1:0] REG_MAP_WIDTH  = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_MAP_HEIGHT = CFG_IDX_BITS'(1);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	localparam logic [1:0] FACE_NORTH = 2'd0;
	localparam logic [1:0] FACE_SOUTH = 2'd1;
	localparam logic [1:0] FACE_WEST  = 2'd2;
	localparam logic [1:0] FACE_EAST  = 2'd3;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK
	} state_t;

	typedef struct packed {
		logic                       op;
		logic [GRID_COORD_BITS-1:0] cell_x;
		logic [GRID_COORD_BITS-1:0] cell_y;
		logic                       cell_wall;
		logic                       step_x_negative;
		logic                       step_y_negative;
		logic [DIST_BITS-1:0]       start_side_x;
		logic [DIST_BITS-1:0]       start_side_y;
		logic [DIST_BITS-1:0]       delta_x;
		logic [DIST_BITS-1:0]       delta_y;
	} cmd_t;

	typedef struct packed {
		logic [GRID_COORD_BITS-1:0] hit_x;
		logic [GRID_COORD_BITS-1:0] hit_y;
		logic [1:0]                 hit_side;
		logic [DIST_BITS-1:0]       final_side_x;
		logic [DIST_BITS-1:0]       final_side_y;
		logic                       escaped;
	} result_t;

	// Saturating add of two side distances
	function automatic logic [DIST_BITS-1:0] sat_add(input logic [DIST_BITS-1:0] a,
		input logic [DIST_BITS-1:0] b);
		logic [DIST_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DIST_BITS] ? DIST_MAX : s[DIST_BITS-1:0];
	endfunction

	// Clamp a size register into 1 .. GRID_SIZE
	function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] v);
		logic [SIZE_BITS-1:0] r;
		r = v;
		if (v == '0) begin
			r = SIZE_BITS'(1);
		end else if (v > GRID_SIZE) begin
			r = GRID_SIZE;
		end
		return r;
	endfunction

endpackage

/* rtl/dda_grid_ray_traversal_unit.sv */
// Top level of the grid ray traversal unit: wall map memory, DDA walker, config registers.
// Depends on rtl/dda_pkg.sv.
//
// Channel  | Handshake              | Word
// ---------+------------------------+------------------------------------------
// command  | start & !busy          | cmd (cmd_t): map write or ray cast
// result   | done, one cycle        | result (result_t): hit cell, face, sides
// config   | cfg_valid & cfg_ready  | cfg_index, cfg_data (map_width/height)
//
// A map write leaves busy low and gives no word. A ray cast makes one step per cycle,
// bound by the single read port of the wall map (the wall bit of the cell just entered
// is checked the cycle after it is read, while the next step is already being computed).
// A cast that starts outside the grid gives its word in the cycle after the accept.
// After reset, a clearing pass writes all 4096 cells of the wall map to zero; busy is
// high during it, config writes are still taken. The receiver cannot stall: done
// marks a word valid for exactly one cycle.

module dda_grid_ray_traversal_unit
	import dda_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  cmd_t                    cmd,
	output logic                    done,
	output result_t                 result,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [SIZE_BITS-1:0]    cfg_data
);

	// Wall map: one bit per cell, addressed {row, column}
	logic mem [2**ADDR_BITS];

	state_t state_q, state_d;

	logic [SIZE_BITS-1:0]       map_w_q, map_h_q;
	logic [ADDR_BITS-1:0]       clr_cnt_q;
	logic [GRID_COORD_BITS-1:0] cur_x_q, cur_y_q;
	logic [DIST_BITS-1:0]       side_x_q, side_y_q, delta_x_q, delta_y_q;
	logic                       neg_x_q, neg_y_q;
	logic [1:0]                 face_q;
	logic                       chk_q;      // a wall read for the current cell is pending
	logic                       rd_wall_q;  // wall map read data
	logic                       done_q;
	result_t                    result_q;

	logic                       accept, cast_acc, cast_out;
	logic [SIZE_BITS-1:0]       w_eff, h_eff;
	logic                       clr_we, step, finish, fin_esc, edge_hit;
	logic [GRID_COORD_BITS-1:0] nxt_x, nxt_y;
	logic [DIST_BITS-1:0]       nxt_sx, nxt_sy;
	logic [1:0]                 nxt_face;
	logic                       mem_we, mem_wdata;
	logic [ADDR_BITS-1:0]       mem_waddr, mem_raddr;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	assign accept   = start && !busy;
	assign cast_acc = accept && (cmd.op == OP_CAST);
	assign w_eff    = eff_size(map_w_q);
	assign h_eff    = eff_size(map_h_q);
	// Start cell outside the configured grid: escape at once
	assign cast_out = ({1'b0, cmd.cell_x} >= w_eff) || ({1'b0, cmd.cell_y} >= h_eff);

	// Next state and walk step
	always_comb begin
		state_d  = state_q;
		clr_we   = 1'b0;
		step     = 1'b0;
		finish   = 1'b0;
		fin_esc  = 1'b0;
		edge_hit = 1'b0;
		nxt_x    = cur_x_q;
		nxt_y    = cur_y_q;
		nxt_sx   = side_x_q;
		nxt_sy   = side_y_q;
		nxt_face = face_q;
		case (state_q)
			ST_CLEAR: begin
				clr_we = 1'b1;
				if (clr_cnt_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cast_acc && !cast_out) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (chk_q && rd_wall_q) begin
					// Entered a wall cell: report it
					finish  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					step = 1'b1;
					// Ties go to the row axis
					if (side_x_q < side_y_q) begin
						nxt_sx   = sat_add(side_x_q, delta_x_q);
						nxt_face = neg_x_q ? FACE_WEST : FACE_EAST;
						edge_hit = neg_x_q ? (cur_x_q == '0)
							: (({1'b0, cur_x_q} + SIZE_BITS'(1)) >= w_eff);
						if (!edge_hit) begin
							nxt_x = neg_x_q ? cur_x_q - GRID_COORD_BITS'(1)
								: cur_x_q + GRID_COORD_BITS'(1);
						end
					end else begin
						nxt_sy   = sat_add(side_y_q, delta_y_q);
						nxt_face = neg_y_q ? FACE_NORTH : FACE_SOUTH;
						edge_hit = neg_y_q ? (cur_y_q == '0)
							: (({1'b0, cur_y_q} + SIZE_BITS'(1)) >= h_eff);
						if (!edge_hit) begin
							nxt_y = neg_y_q ? cur_y_q - GRID_COORD_BITS'(1)
								: cur_y_q + GRID_COORD_BITS'(1);
						end
					end
					if (edge_hit) begin
						finish  = 1'b1;
						fin_esc = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Memory port selection: clearing pass, map write, or read of the cell entered
	assign mem_we    = clr_we || (accept && (cmd.op == OP_WRITE));
	assign mem_waddr = clr_we ? clr_cnt_q : {cmd.cell_y, cmd.cell_x};
	assign mem_wdata = clr_we ? 1'b0 : cmd.cell_wall;
	assign mem_raddr = {nxt_y, nxt_x};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_wall_q <= mem[mem_raddr];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			chk_q     <= 1'b0;
			done_q    <= 1'b0;
			map_w_q   <= GRID_SIZE;
			map_h_q   <= GRID_SIZE;
		end else begin
			state_q <= state_d;
			if (clr_we) begin
				clr_cnt_q <= clr_cnt_q + ADDR_BITS'(1);
			end
			if (cast_acc) begin
				chk_q <= 1'b0;
			end else if (step && !edge_hit) begin
				chk_q <= 1'b1;
			end else if (finish) begin
				chk_q <= 1'b0;
			end
			done_q <= finish || (cast_acc && cast_out);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MAP_WIDTH:  map_w_q <= cfg_data;
					REG_MAP_HEIGHT: map_h_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Ray state and result word
	always_ff @(posedge clk) begin
		if (cast_acc) begin
			cur_x_q   <= cmd.cell_x;
			cur_y_q   <= cmd.cell_y;
			side_x_q  <= cmd.start_side_x;
			side_y_q  <= cmd.start_side_y;
			delta_x_q <= cmd.delta_x;
			delta_y_q <= cmd.delta_y;
			neg_x_q   <= cmd.step_x_negative;
			neg_y_q   <= cmd.step_y_negative;
			face_q    <= FACE_NORTH;
			// Start outside the grid: report the start unchanged
			result_q.hit_x        <= cmd.cell_x;
			result_q.hit_y        <= cmd.cell_y;
			result_q.hit_side     <= FACE_NORTH;
			result_q.final_side_x <= cmd.start_side_x;
			result_q.final_side_y <= cmd.start_side_y;
			result_q.escaped      <= 1'b1;
		end else if (state_q == ST_WALK) begin
			cur_x_q  <= nxt_x;
			cur_y_q  <= nxt_y;
			side_x_q <= nxt_sx;
			side_y_q <= nxt_sy;
			face_q   <= nxt_face;
			if (finish) begin
				result_q.hit_x        <= nxt_x;
				result_q.hit_y        <= nxt_y;
				result_q.hit_side     <= nxt_face;
				result_q.final_side_x <= nxt_sx;
				result_q.final_side_y <= nxt_sy;
				result_q.escaped      <= fin_esc;
			end
		end
	end

	// A word is only produced by a walk or by a cast that starts off the grid
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_WALK) || $past(cast_acc && cast_out))
		else $error("result word without a cast");

	// A wall hit report always follows a pending wall read that came back set
	a_hit_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.escaped) |-> $past(chk_q && rd_wall_q))
		else $error("hit reported without a wall read");

	// A pending read exists only while walking
	a_chk_walk: assert property (@(posedge clk) disable iff (!arst_n)
		chk_q |-> (state_q == ST_WALK))
		else $error("wall read pending outside a walk");

	// The command port stays closed for the whole clearing pass
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> busy && !done)
		else $error("command port open during clearing pass");

endmodule

/* verif/testbench.sv */
// Self-checking testbench for dda_grid_ray_traversal_unit: map writes and ray casts
// checked word by word against an in-bench DDA walker or typed words. Depends on rtl/dda_pkg.sv.
`timescale 1ns / 100ps

module testbench;
	import dda_pkg::*;

	typedef enum bit {
		ROW_CMD,
		ROW_REG
	} row_kind_t;

	// One line of the directed table: either a register write or a command word,
	// optionally with the hit word spelled out by hand.
	typedef struct {
		row_kind_t               kind;
		logic [CFG_IDX_BITS-1:0] reg_idx;
		logic [SIZE_BITS-1:0]    reg_val;
		cmd_t                    word;
		bit                      typed;
		result_t                 want;
	} drill_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	cmd_t                    cmd;
	logic                    done;
	result_t                 result;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [SIZE_BITS-1:0]    cfg_data;

	// Bench copy of the block state: wall bits and the two size registers
	bit                   wall_bits [0:(1 << (2 * GRID_COORD_BITS)) - 1];
	logic [SIZE_BITS-1:0] width_reg;
	logic [SIZE_BITS-1:0] height_reg;

	result_t    expected_hits [$];
	drill_row_t drill [$];
	int         mismatches;

	dda_grid_ray_traversal_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: worst case is far below this (clearing pass plus ~900 words, rays of
	// at most 128 steps each, with idle gaps on the command side).
	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	// A size register of 0 behaves as 1, anything past the map side as the side.
	function automatic int unsigned clamp_size(input logic [SIZE_BITS-1:0] v);
		if (v == '0) return 1;
		if (v > (1 << GRID_COORD_BITS)) return 1 << GRID_COORD_BITS;
		return 32'(v);
	endfunction

	function automatic logic [DIST_BITS-1:0] add_clip(input logic [DIST_BITS-1:0] a,
		input logic [DIST_BITS-1:0] b);
		logic [DIST_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DIST_BITS] ? DIST_MAX : s[DIST_BITS-1:0];
	endfunction

	// Walk one ray through the bench map: step along the smaller side distance
	// (row axis on a tie), stop on the first wall entered or when the next cell
	// would leave the configured grid. The start cell is never tested.
	function automatic result_t trace_ray(input cmd_t c);
		int unsigned          w;
		int unsigned          h;
		int unsigned          x;
		int unsigned          y;
		logic [DIST_BITS-1:0] sx;
		logic [DIST_BITS-1:0] sy;
		logic [1:0]           face;
		bit                   esc;
		bit                   run;
		result_t              r;
		w    = clamp_size(width_reg);
		h    = clamp_size(height_reg);
		x    = 32'(c.cell_x);
		y    = 32'(c.cell_y);
		sx   = c.start_side_x;
		sy   = c.start_side_y;
		face = FACE_NORTH;
		esc  = 1'b0;
		if (x >= w || y >= h) begin
			esc = 1'b1;
		end else begin
			run = 1'b1;
			while (run) begin
				if (sx < sy) begin
					sx   = add_clip(sx, c.delta_x);
					face = c.step_x_negative ? FACE_WEST : FACE_EAST;
					if (c.step_x_negative ? (x == 0) : (x + 1 >= w)) begin
						esc = 1'b1;
						run = 1'b0;
					end else begin
						x = c.step_x_negative ? x - 1 : x + 1;
					end
				end else begin
					sy   = add_clip(sy, c.delta_y);
					face = c.step_y_negative ? FACE_NORTH : FACE_SOUTH;
					if (c.step_y_negative ? (y == 0) : (y + 1 >= h)) begin
						esc = 1'b1;
						run = 1'b0;
					end else begin
						y = c.step_y_negative ? y - 1 : y + 1;
					end
				end
				// the escaping step keeps the last valid cell and reads no wall
				if (run && wall_bits[{GRID_COORD_BITS'(y), GRID_COORD_BITS'(x)}]) run = 1'b0;
			end
		end
		r.hit_x        = GRID_COORD_BITS'(x);
		r.hit_y        = GRID_COORD_BITS'(y);
		r.hit_side     = face;
		r.final_side_x = sx;
		r.final_side_y = sy;
		r.escaped      = esc;
		return r;
	endfunction

	function automatic result_t hit(input int unsigned x, input int unsigned y,
		input logic [1:0] side, input logic [DIST_BITS-1:0] fx,
		input logic [DIST_BITS-1:0] fy, input bit esc);
		result_t r;
		r.hit_x        = GRID_COORD_BITS'(x);
		r.hit_y        = GRID_COORD_BITS'(y);
		r.hit_side     = side;
		r.final_side_x = fx;
		r.final_side_y = fy;
		r.escaped      = esc;
		return r;
	endfunction

	// Cast row; cell_wall is set on purpose since a cast must ignore it.
	function automatic drill_row_t cast_row(input int unsigned x, input int unsigned y,
		input bit nx, input bit ny, input logic [DIST_BITS-1:0] sx,
		input logic [DIST_BITS-1:0] sy, input logic [DIST_BITS-1:0] dx,
		input logic [DIST_BITS-1:0] dy, input bit typed, input result_t want);
		drill_row_t row;
		row.kind                 = ROW_CMD;
		row.reg_idx              = '0;
		row.reg_val              = '0;
		row.word.op              = OP_CAST;
		row.word.cell_x          = GRID_COORD_BITS'(x);
		row.word.cell_y          = GRID_COORD_BITS'(y);
		row.word.cell_wall       = 1'b1;
		row.word.step_x_negative = nx;
		row.word.step_y_negative = ny;
		row.word.start_side_x    = sx;
		row.word.start_side_y    = sy;
		row.word.delta_x         = dx;
		row.word.delta_y         = dy;
		row.typed                = typed;
		row.want                 = want;
		return row;
	endfunction

	// Map write row; every unused field of the word is all ones and must not matter.
	function automatic drill_row_t wall_row(input int unsigned x, input int unsigned y,
		input bit wall);
		drill_row_t row;
		row                = cast_row(x, y, 1'b1, 1'b1, DIST_MAX, DIST_MAX, DIST_MAX,
			DIST_MAX, 1'b0, '0);
		row.word.op        = OP_WRITE;
		row.word.cell_wall = wall;
		return row;
	endfunction

	function automatic drill_row_t reg_row(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [SIZE_BITS-1:0] val);
		drill_row_t row;
		row         = wall_row(0, 0, 1'b0);
		row.kind    = ROW_REG;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	// Half short distances so rays cross many cells; some zeros, full-range
	// values and values near the top to hit ties and saturation.
	function automatic logic [DIST_BITS-1:0] pick_dist();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return DIST_MAX;
			2:       return DIST_MAX - DIST_BITS'($urandom_range(0, 255));
			3, 4:    return DIST_BITS'($urandom);
			default: return DIST_BITS'($urandom_range(0, 32'h0004_0000));
		endcase
	endfunction

	function automatic cmd_t random_word();
		cmd_t        c;
		int unsigned w;
		int unsigned h;
		w                 = clamp_size(width_reg);
		h                 = clamp_size(height_reg);
		c.cell_wall       = $urandom_range(0, 99) < 30;
		c.step_x_negative = 1'($urandom_range(0, 1));
		c.step_y_negative = 1'($urandom_range(0, 1));
		// most cells inside the configured grid, the rest anywhere in the map
		if ($urandom_range(0, 9) == 0) begin
			c.cell_x = GRID_COORD_BITS'($urandom);
			c.cell_y = GRID_COORD_BITS'($urandom);
		end else begin
			c.cell_x = GRID_COORD_BITS'($urandom_range(0, w - 1));
			c.cell_y = GRID_COORD_BITS'($urandom_range(0, h - 1));
		end
		if ($urandom_range(0, 99) < 35) begin
			// map write: junk in the fields that a write ignores
			c.op           = OP_WRITE;
			c.start_side_x = DIST_BITS'($urandom);
			c.start_side_y = DIST_BITS'($urandom);
			c.delta_x      = DIST_BITS'($urandom);
			c.delta_y      = DIST_BITS'($urandom);
		end else begin
			c.op           = OP_CAST;
			c.start_side_x = pick_dist();
			c.start_side_y = pick_dist();
			c.delta_x      = pick_dist();
			c.delta_y      = pick_dist();
		end
		return c;
	endfunction

	// Present one command word, hold it until taken, then update the bench state.
	// start stays high into the next word unless the caller idles in between.
	task automatic send_word(input cmd_t c, input bit typed, input result_t want);
		result_t r;
		@(negedge clk);
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		if (c.op == OP_CAST) begin
			r = trace_ray(c);
			expected_hits.push_back(typed ? want : r);
		end else begin
			wall_bits[{c.cell_y, c.cell_x}] = c.cell_wall;
		end
	endtask

	// Drop start and wait until every predicted hit word has come out. A map
	// write gives no word, so wait on after that for the last write to land.
	task automatic drain_hits();
		@(negedge clk);
		start <= 1'b0;
		while (expected_hits.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [SIZE_BITS-1:0] val);
		drain_hits();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_MAP_WIDTH) width_reg = val;
		else if (idx == REG_MAP_HEIGHT) height_reg = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int idle_pct, input int count);
		for (int i = 0; i < count; i++) begin
			// now and then hold off until the block has gone fully quiet
			if ($urandom_range(0, 59) == 0) drain_hits();
			while ($urandom_range(0, 99) < idle_pct) begin
				@(negedge clk);
				start <= 1'b0;
			end
			send_word(random_word(), 1'b0, '0);
		end
	endtask

	// Check every hit word against the oldest prediction, field by field.
	always @(posedge clk) begin : hit_check
		result_t w;
		if (arst_n && done) begin
			if (expected_hits.size() == 0) begin
				$error("result word with nothing expected");
				mismatches++;
			end else begin
				w = expected_hits.pop_front();
				if (result.hit_x !== w.hit_x) begin
					$error("hit_x: expected %0d, got %0d", w.hit_x, result.hit_x);
					mismatches++;
				end
				if (result.hit_y !== w.hit_y) begin
					$error("hit_y: expected %0d, got %0d", w.hit_y, result.hit_y);
					mismatches++;
				end
				if (result.hit_side !== w.hit_side) begin
					$error("hit_side: expected %0d, got %0d", w.hit_side, result.hit_side);
					mismatches++;
				end
				if (result.final_side_x !== w.final_side_x) begin
					$error("final_side_x: expected %h, got %h", w.final_side_x,
						result.final_side_x);
					mismatches++;
				end
				if (result.final_side_y !== w.final_side_y) begin
					$error("final_side_y: expected %h, got %h", w.final_side_y,
						result.final_side_y);
					mismatches++;
				end
				if (result.escaped !== w.escaped) begin
					$error("escaped: expected %0d, got %0d", w.escaped, result.escaped);
					mismatches++;
				end
			end
		end
	end

	initial begin
		// drive every input to a known value and hold reset
		arst_n     = 1'b0;
		start      = 1'b0;
		cmd        = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		mismatches = 0;
		width_reg  = GRID_SIZE;
		height_reg = GRID_SIZE;
		foreach (wall_bits[i]) wall_bits[i] = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table. The block starts with a 64 x 64 grid and an empty map;
		// the first word waits out the clearing pass on busy.
		// edges of the grid: escape south, west, north, east
		drill.push_back(cast_row(0, 63, 0, 0, 1, 0, 7, 5, 1,
			hit(0, 63, FACE_SOUTH, 1, 5, 1)));
		drill.push_back(cast_row(0, 10, 1, 0, 0, 1, 9, 3, 1,
			hit(0, 10, FACE_WEST, 9, 1, 1)));
		// equal side distances step along the row axis
		drill.push_back(cast_row(7, 0, 0, 1, 4, 4, 1, 2, 1,
			hit(7, 0, FACE_NORTH, 4, 6, 1)));
		drill.push_back(cast_row(63, 5, 0, 0, 0, DIST_MAX, DIST_MAX, 0, 1,
			hit(63, 5, FACE_EAST, DIST_MAX, DIST_MAX, 1)));
		// saturation on the column side, then a long tie walk to the bottom
		drill.push_back(cast_row(62, 5, 0, 0, 32'hFFFF_0000, DIST_MAX, 32'h0002_0000, 0,
			0, '0));
		// a wall on the start cell must not stop the ray
		drill.push_back(wall_row(5, 3, 1));
		drill.push_back(wall_row(2, 3, 1));
		drill.push_back(cast_row(2, 3, 0, 0, 0, DIST_MAX, 1, DIST_MAX, 1,
			hit(5, 3, FACE_EAST, 3, DIST_MAX, 0)));
		drill.push_back(wall_row(6, 3, 1));
		drill.push_back(cast_row(9, 3, 1, 0, 0, DIST_MAX, 1, DIST_MAX, 1,
			hit(6, 3, FACE_WEST, 3, DIST_MAX, 0)));
		// zero distances: every step is a tie
		drill.push_back(cast_row(30, 30, 0, 1, 0, 0, 0, 0, 1,
			hit(30, 0, FACE_NORTH, 0, 0, 1)));
		drill.push_back(wall_row(63, 63, 1));
		drill.push_back(cast_row(63, 60, 0, 0, DIST_MAX, 0, 0, 10, 1,
			hit(63, 63, FACE_SOUTH, DIST_MAX, 30, 0)));
		// narrow grid: a start outside it escapes at once, unchanged
		drill.push_back(reg_row(REG_MAP_WIDTH, 8));
		drill.push_back(cast_row(20, 0, 0, 0, 123, 456, 1, 1, 1,
			hit(20, 0, FACE_NORTH, 123, 456, 1)));
		drill.push_back(cast_row(0, 0, 0, 0, 0, DIST_MAX, 1, DIST_MAX, 1,
			hit(7, 0, FACE_EAST, 8, DIST_MAX, 1)));
		// map writes ignore the configured size
		drill.push_back(wall_row(40, 40, 1));
		// zero registers act as a 1 x 1 grid
		drill.push_back(reg_row(REG_MAP_WIDTH, 0));
		drill.push_back(reg_row(REG_MAP_HEIGHT, 0));
		drill.push_back(cast_row(0, 0, 0, 0, 0, 0, 0, 1, 1,
			hit(0, 0, FACE_SOUTH, 0, 1, 1)));
		drill.push_back(cast_row(1, 0, 0, 0, DIST_MAX, 0, 5, 5, 1,
			hit(1, 0, FACE_NORTH, DIST_MAX, 0, 1)));
		// oversize register clamps to the full map
		drill.push_back(reg_row(REG_MAP_WIDTH, 127));
		drill.push_back(reg_row(REG_MAP_HEIGHT, 64));
		drill.push_back(cast_row(40, 30, 0, 0, DIST_MAX, 0, 0, 1, 1,
			hit(40, 40, FACE_SOUTH, DIST_MAX, 10, 0)));
		drill.push_back(cast_row(63, 63, 1, 1, DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX,
			0, '0));

		foreach (drill[i]) begin
			if (drill[i].kind == ROW_REG) write_reg(drill[i].reg_idx, drill[i].reg_val);
			else send_word(drill[i].word, drill[i].typed, drill[i].want);
		end

		// Random phases: sender idles rarely, often, then never. Grid sizes
		// change between phases while the block is quiet.
		write_reg(REG_MAP_WIDTH, 16);
		write_reg(REG_MAP_HEIGHT, 12);
		run_phase(14, 300);
		write_reg(REG_MAP_WIDTH, 64);
		write_reg(REG_MAP_HEIGHT, 127);
		run_phase(84, 300);
		write_reg(REG_MAP_WIDTH, SIZE_BITS'($urandom_range(1, 64)));
		write_reg(REG_MAP_HEIGHT, 33);
		run_phase(0, 300);

		// wait out the last hit word, then watch on for stray output
		drain_hits();
		repeat (16) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/dda_pkg.sv
rtl/dda_grid_ray_traversal_unit.sv
verif/testbench.sv
